// ----- rtl/core/kss_pkg.sv -----
package kss_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;
	localparam logic [1:0] CMD_TEXT   = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic       start;
		idx_t       j_init;
		logic [7:0] key;
	} walk_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		len_t len;
	} walk_rsp_t;

endpackage

// ----- rtl/core/kmp_substring_search_core.sv -----
// channel | handshake            | fields
// in      | in_valid, in_ready   | command, data_byte
// out     | out_valid, out_ready | found, status, loaded_length
//
// clear, start, first or full append and ignored text: straight from transfer to the final commit
// other appends and searched text: a walk first, with a read and a compare for each try,
// run by the walk unit's read-then-compare loop over the two table memories
// in_ready is low from the input transfer until the result is registered
// a held result stalls only the final commit; arst_n clears all control state
module kmp_substring_search_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic                      status,
	output logic [kss_pkg::LEN_W-1:0] loaded_length
);
	import kss_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] st_q;
	logic [1:0] cmd_q;
	len_t       res_q;
	len_t       plen_q;
	idx_t       border_q;
	len_t       matched_q;
	logic       found_q;
	logic       out_valid_q;
	logic       found_o_q;
	logic       status_o_q;
	len_t       loaded_o_q;

	logic       accept;
	logic       plen_nz;
	logic       full;
	logic       walk_app;
	logic       walk_txt;
	logic       fin_go;
	idx_t       border_new;

	len_t       n_plen;
	idx_t       n_border;
	len_t       n_matched;
	logic       n_found;
	logic       n_status;

	walk_req_t  walk_req;
	walk_rsp_t  walk_rsp;
	idx_t       pat_raddr;
	logic [7:0] pat_rdata;
	idx_t       pre_raddr;
	idx_t       pre_rdata;

	assign in_ready      = (st_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign found         = found_o_q;
	assign status        = status_o_q;
	assign loaded_length = loaded_o_q;

	assign plen_nz  = (plen_q != '0);
	assign full     = (plen_q == len_t'(MAX_PATTERN));
	assign walk_app = (command == CMD_APPEND) && !full && plen_nz;
	assign walk_txt = (command == CMD_TEXT) && !found_q && plen_nz;
	assign fin_go   = (st_q == ST_FIN) && (!out_valid_q || out_ready);

	assign walk_req.start  = accept && (walk_app || walk_txt);
	assign walk_req.j_init = (command == CMD_APPEND) ? border_q : matched_q[IDX_W-1:0];
	assign walk_req.key    = data_byte;

	// the first pattern byte has an empty border
	assign border_new = plen_nz ? res_q[IDX_W-1:0] : '0;

	kss_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pattern_ram (
		.clk  (clk),
		.we   (accept && command == CMD_APPEND && !full),
		.waddr(plen_q[IDX_W-1:0]),
		.wdata(data_byte),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	kss_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_PATTERN)
	) u_prefix_ram (
		.clk  (clk),
		.we   (fin_go && cmd_q == CMD_APPEND && !full),
		.waddr(plen_q[IDX_W-1:0]),
		.wdata(border_new),
		.raddr(pre_raddr),
		.rdata(pre_rdata)
	);

	kss_walk_unit u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (walk_req),
		.rsp      (walk_rsp),
		.pat_raddr(pat_raddr),
		.pat_rdata(pat_rdata),
		.pre_raddr(pre_raddr),
		.pre_rdata(pre_rdata)
	);

	always_comb begin
		n_plen    = plen_q;
		n_border  = border_q;
		n_matched = matched_q;
		n_found   = found_q;
		n_status  = 1'b0;
		case (cmd_q)
			CMD_CLEAR: begin
				n_plen    = '0;
				n_border  = '0;
				n_matched = '0;
				n_found   = 1'b0;
			end
			CMD_APPEND: begin
				if (full) begin
					n_status = 1'b1;
				end else begin
					n_border = border_new;
					n_plen   = plen_q + len_t'(1);
				end
			end
			CMD_START: begin
				n_matched = '0;
				n_found   = 1'b0;
			end
			CMD_TEXT: begin
				if (!found_q) begin
					if (!plen_nz) begin
						n_found = 1'b1;
					end else if (res_q >= plen_q) begin
						n_matched = plen_q;
						n_found   = 1'b1;
					end else begin
						n_matched = res_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			plen_q      <= '0;
			border_q    <= '0;
			matched_q   <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) st_q <= walk_req.start ? ST_WALK : ST_FIN;
				end
				ST_WALK: begin
					if (walk_rsp.done) st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						st_q      <= ST_IDLE;
						plen_q    <= n_plen;
						border_q  <= n_border;
						matched_q <= n_matched;
						found_q   <= n_found;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (fin_go)         out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_q <= command;
		if (st_q == ST_WALK && walk_rsp.done) res_q <= walk_rsp.len;
		if (fin_go) begin
			found_o_q  <= n_found;
			status_o_q <= n_status;
			loaded_o_q <= n_plen;
		end
	end

`ifndef SYNTHESIS
	a_ready_walk_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !walk_rsp.busy)
		else $error("input ready while walk unit busy");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= len_t'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q <= plen_q)
		else $error("matched length beyond pattern length");

	a_border_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q == '0 || len_t'(border_q) < plen_q)
		else $error("border not shorter than pattern");
`endif

endmodule

// ----- rtl/core/kss_ram.sv -----
module kss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/kss_walk_unit.sv -----
module kss_walk_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  kss_pkg::walk_req_t  req,
	output kss_pkg::walk_rsp_t  rsp,
	output kss_pkg::idx_t       pat_raddr,
	input  logic [7:0]          pat_rdata,
	output kss_pkg::idx_t       pre_raddr,
	input  kss_pkg::idx_t       pre_rdata
);
	import kss_pkg::*;

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_READ = 2'd1;
	localparam logic [1:0] W_CMP  = 2'd2;

	logic [1:0] state_q;
	idx_t       j_q;
	logic [7:0] key_q;
	logic       hit;

	assign pat_raddr = j_q;
	assign pre_raddr = j_q - idx_t'(1);
	assign hit       = (key_q == pat_rdata);

	assign rsp.busy = (state_q != W_IDLE);
	assign rsp.done = (state_q == W_CMP) && (hit || j_q == '0);
	assign rsp.len  = hit ? (len_t'(j_q) + len_t'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (req.start) state_q <= W_READ;
				end
				W_READ: state_q <= W_CMP;
				W_CMP: begin
					// mismatch with j above zero falls back one border
					if (!hit && j_q != '0) state_q <= W_READ;
					else                  state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start) begin
			j_q   <= req.j_init;
			key_q <= req.key;
		end else if (state_q == W_CMP && !hit && j_q != '0) begin
			j_q <= pre_rdata;
		end
	end

endmodule

// ----- test/kmp_substring_search_core_tb.sv -----
`timescale 1ns / 100ps

module kmp_substring_search_core_tb;
	import kss_pkg::*;

	localparam int ITEM_TARGET    = 450;
	localparam int QUIET_ITEMS    = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int FILL_ROOM      = 200;

	typedef struct packed {
		logic found;
		logic status;
		len_t len;
	} search_result_t;

	class kmp_scoreboard;
		logic [7:0]     pat_bytes [MAX_PATTERN];
		int unsigned    fail_table [MAX_PATTERN];
		int unsigned    pat_len;
		int unsigned    border;
		int unsigned    matched;
		bit             found_flag;
		search_result_t predicted_results [$];
		int             errors;
		int             checked;
		int             hits;
		int             drops;

		function new();
			pat_len    = 0;
			border     = 0;
			matched    = 0;
			found_flag = 0;
			errors     = 0;
			checked    = 0;
			hits       = 0;
			drops      = 0;
		endfunction

		// grow a matched length by one byte, falling back through the border table
		function int unsigned extend(int unsigned j, logic [7:0] b);
			while (j > 0 && j < MAX_PATTERN && b != pat_bytes[j])
				j = fail_table[j - 1];
			if (j < MAX_PATTERN && b == pat_bytes[j])
				j++;
			return j;
		endfunction

		function void note_command(logic [1:0] cmd, logic [7:0] b);
			search_result_t r;
			int unsigned    j;
			logic           s;
			s = 1'b0;
			case (cmd)
				CMD_CLEAR: begin
					pat_len    = 0;
					border     = 0;
					matched    = 0;
					found_flag = 0;
				end
				CMD_APPEND: begin
					if (pat_len >= MAX_PATTERN) begin
						s = 1'b1;
						drops++;
					end else begin
						pat_bytes[pat_len] = b;
						border = (pat_len == 0) ? 0 : extend(border, b);
						fail_table[pat_len] = border;
						pat_len++;
					end
				end
				CMD_START: begin
					matched    = 0;
					found_flag = 0;
				end
				default: begin
					if (!found_flag) begin
						if (pat_len == 0) begin
							found_flag = 1;
						end else begin
							j = extend(matched, b);
							if (j >= pat_len) begin
								j = pat_len;
								found_flag = 1;
							end
							matched = j;
						end
						if (found_flag)
							hits++;
					end
				end
			endcase
			r.found  = found_flag;
			r.status = s;
			r.len    = len_t'(pat_len);
			predicted_results.insert(predicted_results.size(), r);
		endfunction

		function void check_result(logic f, logic s, len_t len);
			search_result_t want;
			if (predicted_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result found=%0b status=%0b loaded_length=%0d",
					$time, f, s, len);
				return;
			end
			want = predicted_results.pop_front();
			checked++;
			if (want.found !== f || want.status !== s || want.len !== len) begin
				errors++;
				$display({"%0t: mismatch expected found=%0b status=%0b loaded_length=%0d,",
					" actual found=%0b status=%0b loaded_length=%0d"},
					$time, want.found, want.status, want.len, f, s, len);
			end
		endfunction

		function int pending();
			return predicted_results.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic       found;
	logic       status;
	len_t       loaded_length;

	kmp_scoreboard sb;
	int            items_sent;
	int            idle_cycles;
	bit            quiet;
	bit            held_off;
	bit            filled_once;

	kmp_substring_search_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.status        (status),
		.loaded_length (loaded_length)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	task automatic offer_item(input logic [1:0] cmd, input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, b);
		items_sent++;
	endtask

	task automatic run_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) offer_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	// maybe clear, load a short pattern over a small alphabet, maybe start, then stream text
	task automatic run_search_sequence();
		logic [7:0] alpha [3];
		logic [7:0] pat [$];
		logic [7:0] txt [$];
		logic [7:0] ch;
		int         nsym;
		int         plen;
		int         tlen;
		int         at;
		nsym = $urandom_range(1, 3);
		foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) != 0)
			offer_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
		plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
		repeat (plen) begin
			ch = alpha[$urandom_range(0, nsym - 1)];
			pat.insert(pat.size(), ch);
			offer_item(CMD_APPEND, ch);
		end
		if ($urandom_range(0, 5) != 0)
			offer_item(CMD_START, 8'($urandom_range(0, 255)));
		tlen = $urandom_range(3, 16);
		repeat (tlen) txt.insert(txt.size(), alpha[$urandom_range(0, nsym - 1)]);
		if (plen > 0 && $urandom_range(0, 1) == 1) begin
			at = $urandom_range(0, tlen);
			foreach (pat[k]) txt.insert(at + k, pat[k]);
		end
		foreach (txt[k]) begin
			// an append in the middle of a search now and then
			if ($urandom_range(0, 19) == 0)
				offer_item(CMD_APPEND, alpha[$urandom_range(0, nsym - 1)]);
			offer_item(CMD_TEXT, txt[k]);
		end
	endtask

	// fill the pattern to capacity, push past it, then search a long text
	task automatic run_fill_sequence();
		logic [7:0] alpha [2];
		int         nsym;
		int         extra;
		int         tlen;
		nsym = $urandom_range(1, 2);
		foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
		offer_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
		repeat (MAX_PATTERN - 1) offer_item(CMD_APPEND, alpha[0]);
		offer_item(CMD_APPEND, alpha[nsym - 1]);
		extra = $urandom_range(1, 3);
		repeat (extra) offer_item(CMD_APPEND, 8'($urandom_range(0, 255)));
		offer_item(CMD_START, 8'($urandom_range(0, 255)));
		tlen = $urandom_range(MAX_PATTERN, MAX_PATTERN + 12);
		for (int k = 0; k < tlen; k++) begin
			if (k == tlen / 2)
				offer_item(CMD_APPEND, alpha[0]);
			offer_item(CMD_TEXT,
				(k == tlen - 1) ? alpha[nsym - 1] : alpha[$urandom_range(0, nsym - 1)]);
		end
	endtask

	// receiver: random stalls plus one long hold-off to back up the input
	initial begin
		out_ready = 1'b0;
		held_off  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sb.checked >= 150) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid)
				sb.check_result(found, status, loaded_length);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, idle_cycles, sb.pending());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		sb          = new();
		items_sent  = 0;
		quiet       = 1'b0;
		filled_once = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_CLEAR;
		data_byte   = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern: text matches at once, further text ignored until a start
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'hFF);
		offer_item(CMD_START, 8'h00);
		offer_item(CMD_TEXT, 8'h5A);
		// pattern with a border, match found only after a fallback
		offer_item(CMD_APPEND, 8'h00);
		offer_item(CMD_APPEND, 8'hFF);
		offer_item(CMD_APPEND, 8'h00);
		offer_item(CMD_START, 8'hFF);
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'hFF);
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'h11);
		// append while found is set keeps it set
		offer_item(CMD_APPEND, 8'hFF);
		offer_item(CMD_START, 8'h00);
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'hFF);
		offer_item(CMD_TEXT, 8'h00);
		offer_item(CMD_TEXT, 8'hFF);
		offer_item(CMD_CLEAR, 8'hFF);
		offer_item(CMD_TEXT, 8'h80);
		offer_item(CMD_APPEND, 8'hAA);
		offer_item(CMD_APPEND, 8'hAA);
		offer_item(CMD_START, 8'h55);
		offer_item(CMD_TEXT, 8'hAA);
		offer_item(CMD_TEXT, 8'h55);
		offer_item(CMD_TEXT, 8'hAA);
		offer_item(CMD_TEXT, 8'hAA);

		while (items_sent < ITEM_TARGET) begin
			quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
			if (!filled_once && items_sent > 120) begin
				filled_once = 1'b1;
				run_fill_sequence();
			end else if ($urandom_range(0, 4) == 0) begin
				run_noise();
			end else if (items_sent < ITEM_TARGET - FILL_ROOM
				&& $urandom_range(0, 39) == 0) begin
				run_fill_sequence();
			end else begin
				run_search_sequence();
			end
		end
		quiet = 1'b1;
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d results, with %0d matches found",
			items_sent, sb.checked, sb.hits);
		$display("and %0d appends dropped on a full pattern, one long output stall",
			sb.drops);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
